// ===== hdl/isort_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package isort_pkg;

  localparam int DEPTH   = 32;
  localparam int VALUE_W = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [CNT_W-1:0]          count_t;

  // Operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT
  } cell_op_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  // What a cell shows its neighbours
  typedef struct packed {
    logic   valid;
    value_t value;
    logic   ge;
  } cell_link_t;

  typedef struct packed {
    cell_op_t op;
    value_t   new_value;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/isort_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface isort_in_if;
  logic                  valid;
  logic                  ready;
  isort_pkg::value_t     sample_value;
  logic                  is_final;

  modport source (output valid, output sample_value, output is_final, input ready);
  modport sink   (input valid, input sample_value, input is_final, output ready);
endinterface

interface isort_out_if;
  logic                  valid;
  logic                  ready;
  isort_pkg::value_t     sorted_value;
  logic                  end_of_run;
  logic                  overflowed;

  modport source (output valid, output sorted_value, output end_of_run, output overflowed,
                  input ready);
  modport sink   (input valid, input sorted_value, input end_of_run, input overflowed,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/isort_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isort_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  isort_pkg::cell_cmd_t  cmd,
  input  isort_pkg::cell_link_t from_prev,
  input  isort_pkg::cell_link_t from_next,
  output isort_pkg::cell_link_t link
);

  logic              valid_r;
  logic              valid_nxt;
  isort_pkg::value_t value_r;
  isort_pkg::value_t value_nxt;
  logic              ge;

  // The new word belongs at or before this cell (in front of equal values)
  assign ge = !valid_r || (value_r >= cmd.new_value);

  assign link.valid = valid_r;
  assign link.value = value_r;
  assign link.ge    = ge;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    case (cmd.op)
      isort_pkg::OP_INSERT: begin
        if (ge) begin
          if (from_prev.ge) begin
            // make room: take the neighbour's entry
            valid_nxt = from_prev.valid;
            value_nxt = from_prev.value;
          end else begin
            valid_nxt = 1'b1;
            value_nxt = cmd.new_value;
          end
        end
      end
      isort_pkg::OP_SHIFT: begin
        valid_nxt = from_next.valid;
        value_nxt = from_next.value;
      end
      default: begin
        valid_nxt = valid_r;
        value_nxt = value_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/insertion_sorter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Insertion sorter. Signed 32-bit words arrive on in_ch and are kept in ascending order in
// a row of 32 cells; a new word goes in front of equal words already held. While loading,
// one word is taken every cycle: all cells compare the incoming word with their own entry
// at once and those at or above the insertion point shift up by one place in the same
// cycle. Once the store holds 32 words, further words are dropped and the set is flagged
// as overflowed. The word marked is_final is inserted (or dropped) like any other and then
// the whole store is emitted on out_ch, lowest first, one word per cycle as fast as the
// sink takes them, by shifting the chain towards cell 0; the last word of the set carries
// end_of_run and every word of the set carries overflowed. in_ch is held off (ready low)
// while the store drains; the next set may start loading while the last word of the
// previous set still waits in the output register.

module insertion_sorter_top (
  input  logic               clk,
  input  logic               rst_n,
  isort_in_if.sink           in_ch,
  isort_out_if.source        out_ch
);

  localparam int DEPTH = isort_pkg::DEPTH;

  isort_pkg::state_t     state_r;
  isort_pkg::state_t     state_nxt;
  isort_pkg::count_t     fill_count_r;
  isort_pkg::count_t     fill_count_nxt;
  logic                  dropped_r;
  logic                  dropped_nxt;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  isort_pkg::value_t     out_value_r;
  isort_pkg::value_t     out_value_nxt;
  logic                  out_end_r;
  logic                  out_end_nxt;
  logic                  out_ovf_r;
  logic                  out_ovf_nxt;

  isort_pkg::cell_cmd_t  cmd;
  isort_pkg::cell_link_t links [DEPTH];
  logic [DEPTH-1:0]      valid_vec;
  logic                  store_full;
  logic                  out_load;

  assign store_full = (fill_count_r == isort_pkg::count_t'(DEPTH));

  // Cell chain: each cell sees its lower and upper neighbour
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    isort_pkg::cell_link_t from_prev;
    isort_pkg::cell_link_t from_next;

    if (i == 0) begin : g_first
      assign from_prev = '{valid: 1'b0, value: '0, ge: 1'b0};
    end else begin : g_mid_lo
      assign from_prev = links[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign from_next = '{valid: 1'b0, value: '0, ge: 1'b1};
    end else begin : g_mid_hi
      assign from_next = links[i+1];
    end

    isort_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .from_prev (from_prev),
      .from_next (from_next),
      .link      (links[i])
    );

    assign valid_vec[i] = links[i].valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= isort_pkg::ST_LOAD;
      fill_count_r <= '0;
      dropped_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_count_r <= fill_count_nxt;
      dropped_r    <= dropped_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Output word register: payload needs no reset
  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_end_r   <= out_end_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    fill_count_nxt = fill_count_r;
    dropped_nxt    = dropped_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_end_nxt    = out_end_r;
    out_ovf_nxt    = out_ovf_r;
    cmd.op         = isort_pkg::OP_HOLD;
    cmd.new_value  = in_ch.sample_value;
    in_ch.ready    = 1'b0;
    out_load       = 1'b0;

    case (state_r)
      isort_pkg::ST_LOAD: begin
        // ready stays high throughout loading, so valid alone marks an accepted word
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (store_full) begin
            // drop the word, remember it for the whole set
            dropped_nxt = 1'b1;
          end else begin
            cmd.op         = isort_pkg::OP_INSERT;
            fill_count_nxt = fill_count_r + isort_pkg::count_t'(1);
          end
          if (in_ch.is_final) begin
            state_nxt = isort_pkg::ST_DRAIN;
          end
        end
      end
      isort_pkg::ST_DRAIN: begin
        out_load = !out_valid_r || out_ch.ready;
        if (out_load) begin
          // pop cell 0 into the output register and advance the chain
          cmd.op         = isort_pkg::OP_SHIFT;
          out_valid_nxt  = 1'b1;
          out_value_nxt  = links[0].value;
          out_end_nxt    = (fill_count_r == isort_pkg::count_t'(1));
          out_ovf_nxt    = dropped_r;
          fill_count_nxt = fill_count_r - isort_pkg::count_t'(1);
          if (fill_count_r == isort_pkg::count_t'(1)) begin
            state_nxt   = isort_pkg::ST_LOAD;
            dropped_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = isort_pkg::ST_LOAD;
      end
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_value = out_value_r;
  assign out_ch.end_of_run   = out_end_r;
  assign out_ch.overflowed   = out_ovf_r;

  // The number of held entries tracks the fill count, and cell 0 holds one unless the store is empty
  a_fill_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(valid_vec) == int'(fill_count_r)) &&
    (valid_vec[0] || (fill_count_r == '0)))
    else $error("cell valid bits disagree with fill count");

  // A drain never runs on an empty store
  a_drain_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == isort_pkg::ST_DRAIN) |-> (fill_count_r != '0))
    else $error("drain with empty store");

  // Loading the last word of a set returns to loading with an empty store
  a_end_returns_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_end_nxt) |=> ((state_r == isort_pkg::ST_LOAD) &&
                                   (fill_count_r == '0) && !dropped_r))
    else $error("set end did not return to load");

  // Overflow is only flagged once the store has been full
  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(dropped_r) && ($past(state_r) == isort_pkg::ST_LOAD)) |->
      (fill_count_r == isort_pkg::count_t'(DEPTH)))
    else $error("word dropped with room in store");

endmodule

`default_nettype wire
